### src/c8ie_pkg.sv
package c8ie_pkg;

	// Sizes
	localparam int STACK_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int ADDR_W          = 12;

	// Program counter reset value and sequential steps
	localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
	localparam logic [ADDR_W-1:0] PC_STEP  = 12'h002;
	localparam logic [ADDR_W-1:0] PC_SKIP  = 12'h004;

	// Full instruction words decoded exactly in group 0
	localparam logic [15:0] WORD_CLS = 16'h00E0;
	localparam logic [15:0] WORD_RET = 16'h00EE;

	// Instruction groups (top nibble)
	localparam logic [3:0] GRP_SYS     = 4'h0;
	localparam logic [3:0] GRP_JP      = 4'h1;
	localparam logic [3:0] GRP_CALL    = 4'h2;
	localparam logic [3:0] GRP_SE_IMM  = 4'h3;
	localparam logic [3:0] GRP_SNE_IMM = 4'h4;
	localparam logic [3:0] GRP_SE_REG  = 4'h5;
	localparam logic [3:0] GRP_LD      = 4'h6;
	localparam logic [3:0] GRP_ADD     = 4'h7;
	localparam logic [3:0] GRP_SNE_REG = 4'h9;
	localparam logic [3:0] GRP_LDI     = 4'hA;
	localparam logic [3:0] GRP_JP_V0   = 4'hB;
	localparam logic [3:0] GRP_RND     = 4'hC;

	// Operation class handed from decode to execute
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLS,
		OP_RET,
		OP_JP,
		OP_CALL,
		OP_SE_IMM,
		OP_SNE_IMM,
		OP_SE_REG,
		OP_SNE_REG,
		OP_LD,
		OP_ADD,
		OP_LDI,
		OP_JP_V0,
		OP_RND
	} op_t;

	// Decoded instruction word
	typedef struct packed {
		op_t               op;
		logic [3:0]        x;
		logic [3:0]        y;
		logic [7:0]        nn;
		logic [ADDR_W-1:0] nnn;
	} dec_t;

	// One result word
	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic              clear_display;
		logic              reg_write;
		logic [3:0]        reg_index;
		logic [7:0]        reg_value;
		logic [ADDR_W-1:0] index_value;
		logic              unimplemented;
		logic              stack_fault;
	} res_t;

endpackage

### src/c8ie_front.sv
module c8ie_front
	import c8ie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] instruction_word,
	input  logic [7:0]  random_byte,
	output logic        push,
	output dec_t        push_data,
	input  logic        push_ready
);

	dec_t dec;
	logic f_vld_s1;
	dec_t f_dec_s1;

	// Classify the incoming word
	always_comb begin
		dec.op  = OP_NOP;
		dec.x   = instruction_word[11:8];
		dec.y   = instruction_word[7:4];
		dec.nn  = instruction_word[7:0];
		dec.nnn = instruction_word[11:0];
		case (instruction_word[15:12])
			GRP_SYS: begin
				if (instruction_word == WORD_CLS) begin
					dec.op = OP_CLS;
				end else if (instruction_word == WORD_RET) begin
					dec.op = OP_RET;
				end else begin
					dec.op = OP_NOP;
				end
			end
			GRP_JP:      dec.op = OP_JP;
			GRP_CALL:    dec.op = OP_CALL;
			GRP_SE_IMM:  dec.op = OP_SE_IMM;
			GRP_SNE_IMM: dec.op = OP_SNE_IMM;
			GRP_SE_REG:  dec.op = OP_SE_REG;
			GRP_LD:      dec.op = OP_LD;
			GRP_ADD:     dec.op = OP_ADD;
			GRP_SNE_REG: dec.op = OP_SNE_REG;
			GRP_LDI:     dec.op = OP_LDI;
			GRP_JP_V0:   dec.op = OP_JP_V0;
			GRP_RND: begin
				// mask the random byte here so execute only copies it
				dec.op = OP_RND;
				dec.nn = random_byte & instruction_word[7:0];
			end
			default:     dec.op = OP_NOP;
		endcase
	end

	assign push      = f_vld_s1;
	assign push_data = f_dec_s1;
	assign in_ready  = !f_vld_s1 || push_ready;

	// Hold a decoded word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			f_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_dec_s1 <= dec;
		end
	end

endmodule

### src/c8ie_queue.sv
module c8ie_queue
	import c8ie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	output logic push_ready,
	input  logic pop,
	output dec_t head,
	output logic head_valid
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dec_t          mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q < CW'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

### src/c8ie_back.sv
module c8ie_back
	import c8ie_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,
	input  dec_t              head,
	input  logic              head_valid,
	output logic              pop,
	output res_t              res,
	output logic              res_valid,
	input  logic              res_ready
);

	localparam int SAW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	// Architectural state
	logic [ADDR_W-1:0] pc_q;
	logic [SP_W-1:0]   sp_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        v0_q;
	logic [15:0]       rf_vld_q;
	logic [7:0]        rf_mem [16];
	logic [ADDR_W-1:0] stk_mem [STACK_DEPTH];

	// Execute stage
	logic              s2_vld_q;
	dec_t              s2_q;
	logic [7:0]        rx_s2;
	logic [7:0]        ry_s2;
	logic [ADDR_W-1:0] stk_rd_s2;

	// Output register
	logic res_vld_q;
	res_t res_q;

	logic              exec_fire;
	logic              take;
	dec_t              nxt;
	logic [ADDR_W-1:0] pc_seq;
	logic [ADDR_W-1:0] pc_n;
	logic [SP_W-1:0]   sp_n;
	logic [SP_W-1:0]   sp_after;
	logic [ADDR_W-1:0] idx_n;
	logic              stk_we;
	logic [SAW-1:0]    stk_wa;
	logic [SAW-1:0]    stk_ra;
	logic              stk_fire;
	logic              rg_fire;
	res_t              r;

	assign exec_fire = s2_vld_q && (!res_vld_q || res_ready);
	assign take      = head_valid && (!s2_vld_q || exec_fire);
	assign pop       = take;
	assign nxt       = take ? head : s2_q;
	assign pc_seq    = pc_q + PC_STEP;

	// Carry out the word in execute
	always_comb begin
		pc_n   = pc_seq;
		sp_n   = sp_q;
		idx_n  = idx_q;
		stk_we = 1'b0;
		stk_wa = '0;
		r      = '0;
		case (s2_q.op)
			OP_CLS: r.clear_display = 1'b1;
			OP_RET: begin
				if (sp_q == '0) begin
					r.stack_fault = 1'b1;
					sp_n = SP_W'(STACK_DEPTH - 1);
				end else begin
					sp_n = sp_q - 1'b1;
				end
				pc_n = stk_rd_s2;
			end
			OP_JP: pc_n = s2_q.nnn;
			OP_CALL: begin
				stk_we = 1'b1;
				if (sp_q >= SP_W'(STACK_DEPTH)) begin
					r.stack_fault = 1'b1;
					stk_wa = '0;
					sp_n = SP_W'(1);
				end else begin
					stk_wa = sp_q[SAW-1:0];
					sp_n = sp_q + 1'b1;
				end
				pc_n = s2_q.nnn;
			end
			OP_SE_IMM:  if (rx_s2 == s2_q.nn) pc_n = pc_q + PC_SKIP;
			OP_SNE_IMM: if (rx_s2 != s2_q.nn) pc_n = pc_q + PC_SKIP;
			OP_SE_REG:  if (rx_s2 == ry_s2) pc_n = pc_q + PC_SKIP;
			OP_SNE_REG: if (rx_s2 != ry_s2) pc_n = pc_q + PC_SKIP;
			OP_LD: begin
				r.reg_write = 1'b1;
				r.reg_index = s2_q.x;
				r.reg_value = s2_q.nn;
			end
			OP_ADD: begin
				r.reg_write = 1'b1;
				r.reg_index = s2_q.x;
				r.reg_value = rx_s2 + s2_q.nn;
			end
			OP_LDI: idx_n = s2_q.nnn;
			OP_JP_V0: pc_n = s2_q.nnn + {4'b0000, v0_q};
			OP_RND: begin
				r.reg_write = 1'b1;
				r.reg_index = s2_q.x;
				r.reg_value = s2_q.nn;
			end
			OP_NOP: r.unimplemented = 1'b1;
			default: r.unimplemented = 1'b1;
		endcase
		r.next_pc     = pc_n;
		r.index_value = idx_n;
	end

	assign stk_fire = exec_fire && stk_we;
	assign rg_fire  = exec_fire && r.reg_write;

	// Stack entry a return would use once this edge has settled
	assign sp_after = exec_fire ? sp_n : sp_q;
	assign stk_ra   = (sp_after == '0) ? SAW'(STACK_DEPTH - 1) : sp_after[SAW-1:0] - 1'b1;

	// Control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_RESET;
			sp_q      <= '0;
			idx_q     <= '0;
			v0_q      <= '0;
			rf_vld_q  <= '0;
			s2_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_data;
			end else if (exec_fire) begin
				pc_q <= pc_n;
			end
			if (exec_fire) begin
				sp_q  <= sp_n;
				idx_q <= idx_n;
			end
			if (rg_fire) begin
				rf_vld_q[r.reg_index] <= 1'b1;
				if (r.reg_index == '0) begin
					v0_q <= r.reg_value;
				end
			end
			if (take) begin
				s2_vld_q <= 1'b1;
			end else if (exec_fire) begin
				s2_vld_q <= 1'b0;
			end
			if (exec_fire) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Register file and stack: write on execute, read for the next word with bypass
	always_ff @(posedge clk) begin
		if (rg_fire) begin
			rf_mem[r.reg_index] <= r.reg_value;
		end
		if (rg_fire && r.reg_index == nxt.x) begin
			rx_s2 <= r.reg_value;
		end else begin
			rx_s2 <= rf_vld_q[nxt.x] ? rf_mem[nxt.x] : 8'h00;
		end
		if (rg_fire && r.reg_index == nxt.y) begin
			ry_s2 <= r.reg_value;
		end else begin
			ry_s2 <= rf_vld_q[nxt.y] ? rf_mem[nxt.y] : 8'h00;
		end
		if (stk_fire) begin
			stk_mem[stk_wa] <= pc_seq;
		end
		if (stk_fire && stk_wa == stk_ra) begin
			stk_rd_s2 <= pc_seq;
		end else begin
			stk_rd_s2 <= stk_mem[stk_ra];
		end
		if (take) begin
			s2_q <= head;
		end
		if (exec_fire) begin
			res_q <= r;
		end
	end

	assign res       = res_q;
	assign res_valid = res_vld_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_call_push: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && s2_q.op == OP_CALL && sp_q < SP_W'(STACK_DEPTH)
		|=> sp_q == $past(sp_q) + 1'b1)
		else $error("call did not advance stack pointer");

	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> !(res_q.reg_write && res_q.unimplemented))
		else $error("register write on unimplemented word");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> res_vld_q)
		else $error("executed word lost at output");

endmodule

### src/chip8_instruction_execute.sv
// Throughput: one instruction word per cycle while out_ready stays high.
// The register file and return stack are read ahead of execute, with bypass
// from the word executing then.
// Reset: PC loads 0x200, byte registers, index and stack pointer clear; stack
// entries stay undefined until written. A config write loads the PC at once.
module chip8_instruction_execute
	import c8ie_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] start_address,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       instruction_word,
	input  logic [7:0]        random_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] next_pc,
	output logic              clear_display,
	output logic              reg_write,
	output logic [3:0]        reg_index,
	output logic [7:0]        reg_value,
	output logic [ADDR_W-1:0] index_value,
	output logic              unimplemented,
	output logic              stack_fault
);

	logic push;
	dec_t push_data;
	logic push_ready;
	logic pop;
	dec_t head;
	logic head_valid;
	res_t res;

	assign cfg_ready = 1'b1;

	c8ie_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction_word (instruction_word),
		.random_byte      (random_byte),
		.push             (push),
		.push_data        (push_data),
		.push_ready       (push_ready)
	);

	c8ie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	c8ie_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (start_address),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res),
		.res_valid  (out_valid),
		.res_ready  (out_ready)
	);

	// Unpack the result word
	assign next_pc       = res.next_pc;
	assign clear_display = res.clear_display;
	assign reg_write     = res.reg_write;
	assign reg_index     = res.reg_index;
	assign reg_value     = res.reg_value;
	assign index_value   = res.index_value;
	assign unimplemented = res.unimplemented;
	assign stack_fault   = res.stack_fault;

endmodule

### test/tb_top.sv
module tb_top;
	import c8ie_pkg::*;

	localparam int SDEPTH = STACK_DEPTH_DEF;
	localparam int PHASE_WORDS = 220;

	// One row of the directed table: the word, the random byte, and an optional
	// hand-written expectation
	typedef struct packed {
		logic [15:0] word;
		logic [7:0]  rnd;
		logic        typed;
		res_t        want;
	} row_t;

	localparam int NROWS = 29;
	localparam row_t DIRECTED [NROWS] = '{
		'{16'h00E0, 8'h00, 1'b1, '{12'h202, 1'b1, 1'b0, 4'h0, 8'h00, 12'h000, 1'b0, 1'b0}},
		'{16'h6A5C, 8'h00, 1'b1, '{12'h204, 1'b0, 1'b1, 4'hA, 8'h5C, 12'h000, 1'b0, 1'b0}},
		'{16'h7AFF, 8'h00, 1'b1, '{12'h206, 1'b0, 1'b1, 4'hA, 8'h5B, 12'h000, 1'b0, 1'b0}},
		'{16'h3A5B, 8'h00, 1'b1, '{12'h20A, 1'b0, 1'b0, 4'h0, 8'h00, 12'h000, 1'b0, 1'b0}},
		'{16'h4A5B, 8'hFF, 1'b0, '0},
		'{16'h5AB7, 8'h00, 1'b0, '0},
		'{16'h9AB3, 8'h00, 1'b0, '0},
		'{16'hAFFF, 8'h00, 1'b1, '{12'h214, 1'b0, 1'b0, 4'h0, 8'h00, 12'hFFF, 1'b0, 1'b0}},
		'{16'h6B5B, 8'h00, 1'b0, '0},
		'{16'h5AB0, 8'h00, 1'b0, '0},
		'{16'h9AB0, 8'h00, 1'b0, '0},
		'{16'h6FFF, 8'h00, 1'b0, '0},
		'{16'h7F01, 8'h00, 1'b0, '0},
		'{16'hC3FF, 8'hA5, 1'b0, '0},
		'{16'hC300, 8'hFF, 1'b0, '0},
		'{16'hC35A, 8'hFF, 1'b0, '0},
		'{16'h6001, 8'h5A, 1'b0, '0},
		'{16'hBFFF, 8'h00, 1'b1, '{12'h000, 1'b0, 1'b0, 4'h0, 8'h00, 12'hFFF, 1'b0, 1'b0}},
		'{16'h0123, 8'h00, 1'b1, '{12'h002, 1'b0, 1'b0, 4'h0, 8'h00, 12'hFFF, 1'b1, 1'b0}},
		'{16'h0000, 8'h00, 1'b0, '0},
		'{16'h0FFF, 8'hFF, 1'b0, '0},
		'{16'h8123, 8'h00, 1'b0, '0},
		'{16'hD1FF, 8'h00, 1'b0, '0},
		'{16'hE19E, 8'h00, 1'b0, '0},
		'{16'hFFFF, 8'hFF, 1'b0, '0},
		'{16'h1ABC, 8'h00, 1'b0, '0},
		'{16'h2DEF, 8'h00, 1'b0, '0},
		'{16'h00EE, 8'h00, 1'b0, '0},
		'{16'hA000, 8'h00, 1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] start_address = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [15:0]       instruction_word = '0;
	logic [7:0]        random_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ADDR_W-1:0] next_pc;
	logic              clear_display;
	logic              reg_write;
	logic [3:0]        reg_index;
	logic [7:0]        reg_value;
	logic [ADDR_W-1:0] index_value;
	logic              unimplemented;
	logic              stack_fault;

	// Model state of the execute unit
	logic [ADDR_W-1:0] cur_pc;
	logic [4:0]        sp_count;
	logic [ADDR_W-1:0] ret_stack [SDEPTH];
	bit                ret_written [SDEPTH];
	logic [7:0]        vreg [16];
	logic [ADDR_W-1:0] index_reg;

	res_t pending_results [$];
	int   mismatches = 0;
	int   burst_calls = 0;
	int   burst_rets = 0;
	bit   calm = 1'b0;
	bit   long_stall_go = 1'b0;
	int   stall_left = 80;

	chip8_instruction_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.start_address(start_address),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.instruction_word(instruction_word),
		.random_byte(random_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_pc(next_pc),
		.clear_display(clear_display),
		.reg_write(reg_write),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.index_value(index_value),
		.unimplemented(unimplemented),
		.stack_fault(stack_fault)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Run one instruction word through the model state and return its result
	task automatic execute_word(input logic [15:0] w, input logic [7:0] r, output res_t res);
		logic [3:0]        x;
		logic [3:0]        y;
		logic [7:0]        nn;
		logic [ADDR_W-1:0] nnn;
		logic [ADDR_W-1:0] npc;
		x = w[11:8];
		y = w[7:4];
		nn = w[7:0];
		nnn = w[11:0];
		res = '0;
		npc = cur_pc + PC_STEP;
		case (w[15:12])
			GRP_SYS: begin
				if (w == WORD_CLS) begin
					res.clear_display = 1'b1;
				end else if (w == WORD_RET) begin
					// empty stack wraps to the top entry
					if (sp_count == 0) begin
						res.stack_fault = 1'b1;
						sp_count = 5'(SDEPTH - 1);
					end else begin
						sp_count = sp_count - 1'b1;
					end
					npc = ret_stack[sp_count[3:0]];
				end else begin
					res.unimplemented = 1'b1;
				end
			end
			GRP_JP: npc = nnn;
			GRP_CALL: begin
				// full stack wraps back to entry 0
				if (sp_count >= SDEPTH) begin
					res.stack_fault = 1'b1;
					sp_count = '0;
				end
				ret_stack[sp_count[3:0]] = npc;
				ret_written[sp_count[3:0]] = 1'b1;
				sp_count = sp_count + 1'b1;
				npc = nnn;
			end
			GRP_SE_IMM:  if (vreg[x] == nn) npc = npc + PC_STEP;
			GRP_SNE_IMM: if (vreg[x] != nn) npc = npc + PC_STEP;
			GRP_SE_REG:  if (vreg[x] == vreg[y]) npc = npc + PC_STEP;
			GRP_SNE_REG: if (vreg[x] != vreg[y]) npc = npc + PC_STEP;
			GRP_LD: begin
				res.reg_write = 1'b1;
				res.reg_index = x;
				res.reg_value = nn;
			end
			GRP_ADD: begin
				res.reg_write = 1'b1;
				res.reg_index = x;
				res.reg_value = vreg[x] + nn;
			end
			GRP_LDI: index_reg = nnn;
			GRP_JP_V0: npc = nnn + {4'h0, vreg[0]};
			GRP_RND: begin
				res.reg_write = 1'b1;
				res.reg_index = x;
				res.reg_value = r & nn;
			end
			default: res.unimplemented = 1'b1;
		endcase
		if (res.reg_write) vreg[res.reg_index] = res.reg_value;
		cur_pc = npc;
		res.next_pc = npc;
		res.index_value = index_reg;
	endtask

	// A return may only read a stack entry that a call has filled
	function automatic bit ret_ok();
		int slot;
		slot = (sp_count == 0) ? SDEPTH - 1 : int'(sp_count) - 1;
		return ret_written[slot];
	endfunction

	// Pick the next random word: mostly free mix, with call/return bursts
	task automatic gen_item(output logic [15:0] w, output logic [7:0] r);
		logic [15:0] raw;
		logic [3:0]  grp;
		raw = 16'($urandom);
		r = 8'($urandom);
		grp = 4'($urandom_range(0, 15));
		if (burst_calls > 0) begin
			burst_calls--;
			w = {GRP_CALL, raw[11:0]};
		end else if (burst_rets > 0 && ret_ok()) begin
			burst_rets--;
			w = WORD_RET;
		end else begin
			burst_rets = 0;
			if ($urandom_range(0, 49) == 0) begin
				burst_calls = $urandom_range(1, 20);
				burst_rets = $urandom_range(1, 20);
			end
			w = {grp, raw[11:0]};
			case (grp)
				GRP_SYS: begin
					case ($urandom_range(0, 2))
						0: w = WORD_CLS;
						1: w = WORD_RET;
						default: ;
					endcase
				end
				// bias compares toward a hit
				GRP_SE_IMM, GRP_SNE_IMM: if (raw[15]) w[7:0] = vreg[w[11:8]];
				GRP_SE_REG, GRP_SNE_REG: if (raw[15]) w[7:4] = w[11:8];
				default: ;
			endcase
		end
		if (w == WORD_RET && !ret_ok()) w = WORD_CLS;
	endtask

	// Offer one word, hold it until accepted, then queue its expected result
	task automatic send_word(input logic [15:0] w, input logic [7:0] r, input logic typed,
			input res_t want);
		res_t res;
		while (!calm && $urandom_range(0, 99) < 11) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		instruction_word <= w;
		random_byte <= r;
		do @(posedge clk); while (!in_ready);
		execute_word(w, r, res);
		pending_results.push_back(typed ? want : res);
	endtask

	// Stop offering and wait for every expected result word
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_start(input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		cfg_valid <= 1'b1;
		start_address <= addr;
		do @(posedge clk); while (!cfg_ready);
		cur_pc = addr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (long_stall_go && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result word against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("next_pc", want.next_pc, next_pc);
				check_field("clear_display", want.clear_display, clear_display);
				check_field("reg_write", want.reg_write, reg_write);
				check_field("reg_index", want.reg_index, reg_index);
				check_field("reg_value", want.reg_value, reg_value);
				check_field("index_value", want.index_value, index_value);
				check_field("unimplemented", want.unimplemented, unimplemented);
				check_field("stack_fault", want.stack_fault, stack_fault);
			end
		end
	end

	initial begin
		logic [15:0]       w;
		logic [7:0]        r;
		logic [ADDR_W-1:0] phase_start [4];
		cur_pc = PC_RESET;
		sp_count = '0;
		index_reg = '0;
		for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
		for (int i = 0; i < SDEPTH; i++) begin
			ret_stack[i] = '0;
			ret_written[i] = 1'b0;
		end
		phase_start[0] = 12'h000;
		phase_start[1] = 12'hFFF;
		phase_start[2] = 12'($urandom_range(1, 4094));
		phase_start[3] = PC_RESET;

		// Hold reset, then release it
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table from the reset state
		for (int i = 0; i < NROWS; i++)
			send_word(DIRECTED[i].word, DIRECTED[i].rnd, DIRECTED[i].typed, DIRECTED[i].want);
		drain();

		// Random phases, each with its own start address
		for (int p = 0; p < 4; p++) begin
			write_start(phase_start[p]);
			calm = (p == 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 0 && n == PHASE_WORDS / 2) drain();
				if (p == 1 && n == 30) long_stall_go = 1'b1;
				gen_item(w, r);
				send_word(w, r, 1'b0, '0);
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Give up after a generous fixed time
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
